// ===== rtl/smls_pkg.sv =====
// ----------------------------------------------------------------------------
// smls_pkg
// Types and constants for the SIP message line splitter.
// ----------------------------------------------------------------------------
package smls_pkg;

    localparam int MAX_MESSAGE_BYTES = 65536;
    localparam int MAX_LINES         = 256;

    localparam int          BYTE_LIMIT_INT = (MAX_MESSAGE_BYTES > 65535) ? 65535
                                                                         : MAX_MESSAGE_BYTES;
    localparam logic [15:0] BYTE_LIMIT     = 16'(BYTE_LIMIT_INT);
    localparam int          CAP_TOP_INT    = (MAX_LINES > 256) ? 256 : MAX_LINES;
    localparam logic [8:0]  CAP_TOP        = 9'(CAP_TOP_INT);
    localparam logic [8:0]  CAP_MIN        = 9'd2;
    localparam logic [7:0]  CAP_LIM_RESET  = 8'd63;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam logic [1:0] KIND_LINE         = 2'd0;
    localparam logic [1:0] KIND_OK           = 2'd1;
    localparam logic [1:0] KIND_BAD_START    = 2'd2;
    localparam logic [1:0] KIND_OUT_OF_SPACE = 2'd3;

    localparam logic [1:0] LT_START = 2'd0;
    localparam logic [1:0] LT_SIP   = 2'd1;
    localparam logic [1:0] LT_SEP   = 2'd2;
    localparam logic [1:0] LT_SDP   = 2'd3;

    typedef enum logic [5:0] {
        PH_START = 6'b000001,
        PH_SIP   = 6'b000010,
        PH_SDP   = 6'b000100,
        PH_DONE  = 6'b001000,
        PH_BAD   = 6'b010000,
        PH_FULL  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  line_index;
        logic [15:0] line_start;
        logic [15:0] line_length;
        logic [1:0]  line_type;
        logic [7:0]  hdr_first;
        logic [7:0]  hdr_last;
        logic [7:0]  body_first;
        logic [7:0]  body_last;
        logic        last;
    } t_result;

endpackage

// ===== rtl/sip_message_line_splitter_top.sv =====
// ----------------------------------------------------------------------------
// sip_message_line_splitter_top: one byte a cycle while o_stall is low.
// Output words are registered into a 3-word queue; a line plus a status is two words.
// Synchronous active-low reset clears message state, sets line capacity to 64.
// ----------------------------------------------------------------------------
module sip_message_line_splitter_top
    import smls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_msg_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_record_kind,
    output logic [7:0]  o_line_index,
    output logic [15:0] o_line_start,
    output logic [15:0] o_line_length,
    output logic [1:0]  o_line_type,
    output logic [7:0]  o_sip_first_line,
    output logic [7:0]  o_sip_last_line,
    output logic [7:0]  o_sdp_first_line,
    output logic [7:0]  o_sdp_last_line,
    output logic        o_result_last
);

    t_phase      r_phase,       n_phase;
    logic [15:0] r_byte_offset, n_byte_offset;
    logic [15:0] r_line_start,  n_line_start;
    logic [7:0]  r_lines,       n_lines;
    logic        r_prev_cr,     n_prev_cr;
    logic        r_pending,     n_pending;
    logic [7:0]  r_sip_first,   n_sip_first;
    logic [7:0]  r_sip_last,    n_sip_last;
    logic [7:0]  r_sdp_first,   n_sdp_first;
    logic [7:0]  r_sdp_last,    n_sdp_last;
    logic [7:0]  r_cap_lim,     n_cap_lim;

    t_result     r_q [3];
    t_result     n_q [3];
    logic [1:0]  r_cnt,         n_cnt;

    t_result     res0, res1;
    logic [1:0]  step_cnt;
    logic        in_acc, out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = r_cnt > 2'd1;
    assign o_valid = r_cnt != 2'd0;

    always_comb begin
        logic [8:0] cap;
        cap = i_cfg_wdata;
        if (cap < CAP_MIN) begin
            cap = CAP_MIN;
        end
        if (cap > CAP_TOP) begin
            cap = CAP_TOP;
        end
        n_cap_lim = 8'(cap - 9'd1);
    end

    always_comb begin : p_step
        t_phase      ph;
        logic [15:0] off, cls, len;
        logic        pend, pcr, ok, rec_v, rec_full;
        logic [15:0] rec_start, rec_len;
        logic [1:0]  rec_type, kind;
        logic [7:0]  lines_inc, sf, sl, df, dl;
        t_result     res_line, res_stat;

        ph        = r_phase;
        off       = r_byte_offset;
        cls       = r_line_start;
        pend      = r_pending;
        pcr       = r_prev_cr;
        len       = '0;
        ok        = 1'b0;
        rec_v     = 1'b0;
        rec_start = '0;
        rec_len   = '0;
        rec_type  = LT_START;
        lines_inc = r_lines + 8'd1;
        rec_full  = lines_inc >= r_cap_lim;

        if (off < BYTE_LIMIT) begin
            pcr = (i_msg_byte == CH_CR);
            if (pend && ph == PH_SIP) begin
                if (i_msg_byte == CH_SPACE || i_msg_byte == CH_TAB) begin
                    pend = 1'b0;
                end else begin
                    rec_v     = 1'b1;
                    rec_start = cls;
                    rec_len   = off - cls;
                    pend      = 1'b0;
                    if (rec_len == 16'd2) begin
                        ph       = PH_SDP;
                        rec_type = LT_SEP;
                    end else begin
                        rec_type = LT_SIP;
                    end
                    if (rec_full) begin
                        ph = PH_FULL;
                    end
                    cls = off;
                end
            end
            pend = pend && ph == PH_SIP;
            if (i_msg_byte == CH_LF && (ph == PH_START || ph == PH_SIP || ph == PH_SDP)) begin
                len = off + 16'd1 - cls;
                ok  = r_prev_cr && len >= 16'd2;
                if (ph == PH_START) begin
                    if (ok) begin
                        ph        = PH_SIP;
                        rec_v     = 1'b1;
                        rec_start = cls;
                        rec_len   = len;
                        rec_type  = LT_START;
                        if (rec_full) begin
                            ph   = PH_FULL;
                            pend = 1'b0;
                        end
                        cls = off + 16'd1;
                    end else begin
                        ph = PH_BAD;
                    end
                end else if (ph == PH_SIP) begin
                    if (ok) begin
                        pend = 1'b1;
                    end else begin
                        ph = PH_DONE;
                    end
                end else begin
                    if (ok) begin
                        rec_v     = 1'b1;
                        rec_start = cls;
                        rec_len   = len;
                        rec_type  = LT_SDP;
                        if (rec_full) begin
                            ph   = PH_FULL;
                            pend = 1'b0;
                        end
                        cls = off + 16'd1;
                    end else begin
                        ph = PH_DONE;
                    end
                end
            end
            off = off + 16'd1;
        end

        if (i_msg_last && pend && ph == PH_SIP) begin
            rec_v     = 1'b1;
            rec_start = cls;
            rec_len   = off - cls;
            pend      = 1'b0;
            if (rec_len == 16'd2) begin
                ph       = PH_SDP;
                rec_type = LT_SEP;
            end else begin
                rec_type = LT_SIP;
            end
            if (rec_full) begin
                ph = PH_FULL;
            end
            cls = off;
        end

        sf = r_sip_first;
        sl = r_sip_last;
        df = r_sdp_first;
        dl = r_sdp_last;
        if (rec_v && rec_type == LT_SIP) begin
            if (sf == 8'd0) begin
                sf = r_lines;
            end
            sl = r_lines;
        end
        if (rec_v && rec_type == LT_SDP) begin
            if (df == 8'd0) begin
                df = r_lines;
            end
            dl = r_lines;
        end

        if (ph == PH_START || ph == PH_BAD) begin
            kind = KIND_BAD_START;
        end else if (ph == PH_FULL) begin
            kind = KIND_OUT_OF_SPACE;
        end else begin
            kind = KIND_OK;
        end

        res_line.kind        = KIND_LINE;
        res_line.line_index  = r_lines;
        res_line.line_start  = rec_start;
        res_line.line_length = rec_len;
        res_line.line_type   = rec_type;
        res_line.hdr_first   = '0;
        res_line.hdr_last    = '0;
        res_line.body_first  = '0;
        res_line.body_last   = '0;
        res_line.last        = !i_msg_last;

        res_stat.kind        = kind;
        res_stat.line_index  = '0;
        res_stat.line_start  = '0;
        res_stat.line_length = '0;
        res_stat.line_type   = LT_START;
        res_stat.hdr_first   = sf;
        res_stat.hdr_last    = sl;
        res_stat.body_first  = df;
        res_stat.body_last   = dl;
        res_stat.last        = 1'b1;

        res0     = rec_v ? res_line : res_stat;
        res1     = res_stat;
        step_cnt = {1'b0, rec_v} + {1'b0, i_msg_last};

        if (i_msg_last) begin
            n_phase       = PH_START;
            n_byte_offset = '0;
            n_line_start  = '0;
            n_lines       = '0;
            n_prev_cr     = 1'b0;
            n_pending     = 1'b0;
            n_sip_first   = '0;
            n_sip_last    = '0;
            n_sdp_first   = '0;
            n_sdp_last    = '0;
        end else begin
            n_phase       = ph;
            n_byte_offset = off;
            n_line_start  = cls;
            n_lines       = rec_v ? lines_inc : r_lines;
            n_prev_cr     = pcr;
            n_pending     = pend;
            n_sip_first   = sf;
            n_sip_last    = sl;
            n_sdp_first   = df;
            n_sdp_last    = dl;
        end
    end

    always_comb begin : p_queue
        logic [1:0] base;

        n_q  = r_q;
        base = r_cnt;
        if (out_acc) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            base   = r_cnt - 2'd1;
        end
        n_cnt = base;
        if (in_acc) begin
            for (int i = 0; i < 3; i++) begin
                if (step_cnt != 2'd0 && 2'(i) == base) begin
                    n_q[i] = res0;
                end
                if (step_cnt == 2'd2 && 2'(i) == base + 2'd1) begin
                    n_q[i] = res1;
                end
            end
            n_cnt = base + step_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_START;
            r_byte_offset <= '0;
            r_line_start  <= '0;
            r_lines       <= '0;
            r_prev_cr     <= 1'b0;
            r_pending     <= 1'b0;
            r_sip_first   <= '0;
            r_sip_last    <= '0;
            r_sdp_first   <= '0;
            r_sdp_last    <= '0;
            r_cap_lim     <= CAP_LIM_RESET;
            r_cnt         <= '0;
        end else begin
            if (in_acc) begin
                r_phase       <= n_phase;
                r_byte_offset <= n_byte_offset;
                r_line_start  <= n_line_start;
                r_lines       <= n_lines;
                r_prev_cr     <= n_prev_cr;
                r_pending     <= n_pending;
                r_sip_first   <= n_sip_first;
                r_sip_last    <= n_sip_last;
                r_sdp_first   <= n_sdp_first;
                r_sdp_last    <= n_sdp_last;
            end
            if (i_cfg_we) begin
                r_cap_lim <= n_cap_lim;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_record_kind    = r_q[0].kind;
    assign o_line_index     = r_q[0].line_index;
    assign o_line_start     = r_q[0].line_start;
    assign o_line_length    = r_q[0].line_length;
    assign o_line_type      = r_q[0].line_type;
    assign o_sip_first_line = r_q[0].hdr_first;
    assign o_sip_last_line  = r_q[0].hdr_last;
    assign o_sdp_first_line = r_q[0].body_first;
    assign o_sdp_last_line  = r_q[0].body_last;
    assign o_result_last    = r_q[0].last;

`ifndef NO_ASSERTIONS
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_record_kind != KIND_LINE) |-> o_result_last)
        else $error("status word not marked last");

    a_line_no_indices: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_record_kind == KIND_LINE) |->
        (o_sip_first_line == 8'd0 && o_sip_last_line == 8'd0 &&
         o_sdp_first_line == 8'd0 && o_sdp_last_line == 8'd0))
        else $error("line word carries section indices");

    a_message_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_msg_last) |=>
        (r_phase == PH_START && r_byte_offset == 16'd0 && r_lines == 8'd0 && !r_pending))
        else $error("message state not cleared after last byte");
`endif

endmodule
